### rtl/qtc2d_pkg.sv
// Package for the 2D quality-threshold clustering block.
// Holds the sizes, the controller state type and the command/status structs.
// No dependencies.
package qtc2d_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int THR_W      = 34;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1024);
  localparam logic             REG_THR   = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANCHOR,
    ST_SCAN,
    ST_DRAIN,
    ST_NEXT,
    ST_E_ANCHOR,
    ST_E_SCAN,
    ST_E_DRAIN,
    ST_ROUND_END
  } state_t;

  typedef struct packed {
    logic load;
    logic start_round;
    logic begin_scan;
    logic issue;
    logic finish_i;
    logic emit;
    logic end_round;
    logic finish_set;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
    logic i_last;
    logic alive_any;
  } ctl_stat_t;

endpackage

### rtl/qtc2d_ctrl.sv
// Controller state machine for the 2D quality-threshold clustering block.
// Depends on qtc2d_pkg.
module qtc2d_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 last_point,
  input  qtc2d_pkg::ctl_stat_t stat,
  output qtc2d_pkg::ctl_cmd_t  cmd,
  output logic                 busy
);
  import qtc2d_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_point) begin
            cmd.start_round = 1'b1;
            state_nxt       = ST_ANCHOR;
          end
        end
      end
      ST_ANCHOR: begin
        cmd.begin_scan = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.finish_i = 1'b1;
        state_nxt    = stat.i_last ? ST_E_ANCHOR : ST_ANCHOR;
      end
      ST_E_ANCHOR: begin
        cmd.emit       = 1'b1;
        cmd.begin_scan = 1'b1;
        state_nxt      = ST_E_SCAN;
      end
      ST_E_SCAN: begin
        cmd.emit  = 1'b1;
        cmd.issue = 1'b1;
        if (stat.scan_last) state_nxt = ST_E_DRAIN;
      end
      ST_E_DRAIN: begin
        cmd.emit = 1'b1;
        if (stat.pipe_empty) state_nxt = ST_ROUND_END;
      end
      ST_ROUND_END: begin
        cmd.end_round = 1'b1;
        if (stat.alive_any) begin
          cmd.start_round = 1'b1;
          state_nxt       = ST_ANCHOR;
        end else begin
          cmd.finish_set = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/qtc2d_dp.sv
// Datapath: point memory, alive mask, distance pipeline, counting and emission.
// Depends on qtc2d_pkg; driven by qtc2d_ctrl commands.
module qtc2d_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  qtc2d_pkg::ctl_cmd_t                  cmd,
  output qtc2d_pkg::ctl_stat_t                 stat,
  input  logic [qtc2d_pkg::THR_W-1:0]          thr,
  input  logic signed [qtc2d_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [qtc2d_pkg::COORD_BITS-1:0] in_y,
  output logic                                 res_valid,
  output logic [qtc2d_pkg::IDX_W-1:0]          res_index,
  output logic [qtc2d_pkg::IDX_W-1:0]          res_cluster,
  output logic [qtc2d_pkg::CNT_W-1:0]          res_size,
  output logic                                 res_last
);
  import qtc2d_pkg::*;

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_a_r, rd_b_r;

  logic [CNT_W-1:0]      count_r, rem_r, cnt_r, best_cnt_r;
  logic [MAX_POINTS-1:0] alive_r;
  logic [IDX_W-1:0]      i_r, j_r, best_r, cluster_r;
  logic [IDX_W-1:0]      anchor_addr;

  logic             v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0] j1_r, j2_r, j3_r, j4_r;
  logic [DIFF_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]   sx_r, sy_r;
  logic              nb_r;

  logic [THR_W-1:0]  thr_eff;
  logic signed [DIFF_W-1:0] ddx, ddy;
  logic [SUM_W-1:0]  sum;
  logic              hit;

  assign anchor_addr = cmd.emit ? best_r : i_r;
  assign thr_eff     = (thr == '0) ? THR_W'(1) : thr;

  always_ff @(posedge clk) begin
    if (cmd.load && count_r < CNT_W'(MAX_POINTS)) begin
      mem[count_r[IDX_W-1:0]] <= {in_x, in_y};
    end
    rd_a_r <= mem[anchor_addr];
    rd_b_r <= mem[j_r];
  end

  always_comb begin
    ddx = DIFF_W'($signed(rd_a_r[2*COORD_BITS-1:COORD_BITS]))
        - DIFF_W'($signed(rd_b_r[2*COORD_BITS-1:COORD_BITS]));
    ddy = DIFF_W'($signed(rd_a_r[COORD_BITS-1:0])) - DIFF_W'($signed(rd_b_r[COORD_BITS-1:0]));
    sum = SUM_W'(sx_r) + SUM_W'(sy_r);
  end

  assign hit = v4_r && nb_r;

  // payload stages
  always_ff @(posedge clk) begin
    dx_r <= ddx[DIFF_W-1] ? DIFF_W'(-ddx) : DIFF_W'(ddx);
    dy_r <= ddy[DIFF_W-1] ? DIFF_W'(-ddy) : DIFF_W'(ddy);
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    nb_r <= (sum < SUM_W'(thr_eff));
    j2_r <= j1_r;
    j3_r <= j2_r;
    j4_r <= j3_r;
    if (cmd.issue) j1_r <= j_r;
    if (hit && cmd.emit) begin
      res_index   <= j4_r;
      res_cluster <= cluster_r;
      res_size    <= best_cnt_r;
      res_last    <= (rem_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      rem_r      <= '0;
      alive_r    <= '0;
      cluster_r  <= '0;
      i_r        <= '0;
      j_r        <= '0;
      cnt_r      <= '0;
      best_r     <= '0;
      best_cnt_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      v1_r      <= cmd.issue && alive_r[j_r];
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      res_valid <= hit && cmd.emit;
      if (cmd.load && count_r < CNT_W'(MAX_POINTS)) begin
        alive_r[count_r[IDX_W-1:0]] <= 1'b1;
        count_r <= count_r + CNT_W'(1);
        rem_r   <= rem_r + CNT_W'(1);
      end
      if (cmd.start_round) begin
        i_r        <= '0;
        best_r     <= '0;
        best_cnt_r <= '0;
      end
      if (cmd.begin_scan) begin
        j_r   <= '0;
        cnt_r <= '0;
      end
      if (cmd.issue) j_r <= j_r + IDX_W'(1);
      if (hit) begin
        if (cmd.emit) begin
          alive_r[j4_r] <= 1'b0;
          rem_r         <= rem_r - CNT_W'(1);
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (cmd.finish_i) begin
        if (alive_r[i_r] && cnt_r > best_cnt_r) begin
          best_cnt_r <= cnt_r;
          best_r     <= i_r;
        end
        i_r <= i_r + IDX_W'(1);
      end
      if (cmd.finish_set) begin
        count_r   <= '0;
        rem_r     <= '0;
        alive_r   <= '0;
        cluster_r <= '0;
      end else if (cmd.end_round) begin
        cluster_r <= cluster_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    stat.scan_last  = ({1'b0, j_r} == count_r - CNT_W'(1));
    stat.i_last     = ({1'b0, i_r} == count_r - CNT_W'(1));
    stat.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);
    stat.alive_any  = (alive_r != '0);
  end

endmodule

### rtl/quality_threshold_clustering_2d.sv
// Top level of the 2D quality-threshold clustering block.
// Depends on qtc2d_pkg, qtc2d_ctrl and qtc2d_dp.
//
// Usage: points enter on in_point_x/in_point_y, one transaction per cycle with
// start high while busy is low. A non-final point is only stored; busy stays low.
// A transaction with in_last_point high starts clustering: busy stays high
// until every stored point has been emitted once on the out_ ports, each for
// one cycle marked by out_valid; out_last_result flags the final one.
// Clustering runs in rounds; each round scans all N points as anchors against
// all N points through a four-stage distance pipeline (one memory read port
// per side, one pair of 17x17 squarers), then rescans the winner to emit.
// A set takes one round per emitted cluster, so up to N rounds for N points.
// The threshold register lies at byte address 0 of the APB-style port and
// must only be written while busy is low; a value of 0 acts as 1.
// Reset (rst_n low, synchronous) empties the point set, sets the threshold
// to 1024 and leaves the point memory contents undefined.
// The receiver cannot stall: results are never held back.
module quality_threshold_clustering_2d (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [qtc2d_pkg::COORD_BITS-1:0]  in_point_x,
  input  logic signed [qtc2d_pkg::COORD_BITS-1:0]  in_point_y,
  input  logic                                     in_last_point,
  output logic                                     out_valid,
  output logic [qtc2d_pkg::IDX_W-1:0]              out_point_index,
  output logic [qtc2d_pkg::IDX_W-1:0]              out_cluster_number,
  output logic [qtc2d_pkg::CNT_W-1:0]              out_cluster_size,
  output logic                                     out_last_result,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [3:0]                               paddr,
  input  logic [63:0]                              pwdata,
  output logic [63:0]                              prdata,
  output logic                                     pready
);
  import qtc2d_pkg::*;

  ctl_cmd_t         cmd;
  ctl_stat_t        stat;
  logic [THR_W-1:0] thr_r;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_THR) ? {{(64-THR_W){1'b0}}, thr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (psel && penable && pwrite && paddr[3] == REG_THR) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  qtc2d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_point (in_last_point),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  qtc2d_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .thr         (thr_r),
    .in_x        (in_point_x),
    .in_y        (in_point_y),
    .res_valid   (out_valid),
    .res_index   (out_point_index),
    .res_cluster (out_cluster_number),
    .res_size    (out_cluster_size),
    .res_last    (out_last_result)
  );

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside clustering");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cluster_size != '0)
    else $error("empty cluster emitted");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |=> !out_valid)
    else $error("result after final result");

endmodule
